// ===== hdl/rtfd_pkg.sv =====
// Shared constants, types and a helper function for the radar target frame decoder.
`default_nettype none
package rtfd_pkg;

   localparam int FRAME_LENGTH  = 30;
   localparam int SLOT_COUNT    = 3;
   localparam int SLOT_BYTES    = 8;
   localparam int SLOT_BASE     = 5;  // window tap holding slot 0, byte 0 before the shift
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOT_W        = 2;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int RSP_DATA_W    = 88;

   localparam logic [7:0] HDR_BYTE0 = 8'hAA;
   localparam logic [7:0] HDR_BYTE1 = 8'hFF;
   localparam logic [7:0] HDR_BYTE2 = 8'h03;
   localparam logic [7:0] HDR_BYTE3 = 8'h00;
   localparam logic [7:0] FTR_BYTE0 = 8'h55;
   localparam logic [7:0] FTR_BYTE1 = 8'hCC;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_DISTANCE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STILL_SPEED    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DIST_TOLERANCE = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_STATIC_MIN     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_RECEDING_LIMIT = 3'd4;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

   // slot k, byte j lives at frame[k][8*j +: 8]
   typedef logic [SLOT_COUNT-1:0][SLOT_BYTES*8-1:0] frame_type;

   typedef struct packed {
      logic [15:0]        max_distance_mm;
      logic [14:0]        still_speed_cms;
      logic [15:0]        still_distance_tolerance_mm;
      logic [15:0]        static_min_frames;
      logic signed [15:0] receding_limit_cms;
   } cfg_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot_index;
      logic               target_valid;
      logic signed [15:0] pos_x_mm;
      logic signed [15:0] pos_y_mm;
      logic signed [15:0] speed_cms;
      logic [15:0]        distance_mm;
      logic [15:0]        still_frames;
      logic               is_static;
      logic               approaching;
      logic               last_of_frame;
   } result_type;

   // bit 7 of the high byte set means positive
   function automatic logic signed [15:0] decode_sm(input logic [7:0] lo, input logic [7:0] hi);
      logic [15:0] mag;
      mag = {1'b0, hi[6:0], lo};
      return hi[7] ? signed'(mag) : -signed'(mag);
   endfunction

endpackage
`default_nettype wire

// ===== hdl/rtfd_front.sv =====
// Front end: byte window, frame sync detection and frame push into the queue.
`default_nettype none
module rtfd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,   // [7:0] rx_byte
   input  wire logic               q_full,
   output logic                    q_push,
   output rtfd_pkg::frame_type     q_push_data
);
   import rtfd_pkg::*;

   logic [7:0] window_ff [FRAME_LENGTH];
   logic [7:0] window_in [FRAME_LENGTH];
   logic       accept;
   logic       match;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // checked against the window as it will be after this byte shifts in
   assign match = (window_ff[1] == HDR_BYTE0) && (window_ff[2] == HDR_BYTE1) &&
                  (window_ff[3] == HDR_BYTE2) && (window_ff[4] == HDR_BYTE3) &&
                  (window_ff[FRAME_LENGTH-1] == FTR_BYTE0) && (req_tdata == FTR_BYTE1);

   assign q_push = accept && match;

   always_comb begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
         for (int j = 0; j < SLOT_BYTES; j++) begin
            q_push_data[k][8*j +: 8] = window_ff[SLOT_BASE + SLOT_BYTES*k + j];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < FRAME_LENGTH; i++) begin
         window_in[i] = window_ff[i];
      end
      if (accept) begin
         if (match) begin
            for (int i = 0; i < FRAME_LENGTH; i++) begin
               window_in[i] = '0;
            end
         end else begin
            for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
               window_in[i] = window_ff[i+1];
            end
            window_in[FRAME_LENGTH-1] = req_tdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAME_LENGTH; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < FRAME_LENGTH; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

endmodule
`default_nettype wire

// ===== hdl/rtfd_queue.sv =====
// Short frame queue between the front end and the slot decoder.
`default_nettype none
module rtfd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rtfd_pkg::frame_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output logic                    head_valid,
   output rtfd_pkg::frame_type     head_data
);
   import rtfd_pkg::*;

   frame_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/rtfd_back.sv =====
// Back end: per-slot decode, still-frame tracking and the result register.
`default_nettype none
module rtfd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rtfd_pkg::cfg_type  cfg,
   input  wire logic               q_valid,
   input  wire rtfd_pkg::frame_type q_data,
   output logic                    q_pop,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output rtfd_pkg::result_type    out_result
);
   import rtfd_pkg::*;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic               valid;
      logic               still_ok;
      logic               approaching;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] speed;
      logic [15:0]        distance;
   } stage_type;

   logic [SLOT_W-1:0] sel_ff, sel_in;
   logic              s1_valid_ff, s1_valid_in;
   stage_type         s1_ff, s1_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, out_in;
   logic              any_valid_ff, any_valid_in;
   logic [15:0]       prev_ff [SLOT_COUNT];
   logic [15:0]       cnt_ff  [SLOT_COUNT];

   logic              adv_out, move, load;
   logic [63:0]       slot_bytes;
   logic [14:0]       abs_speed;
   logic [15:0]       slot_dist, prev_dist, dist_delta;
   logic [15:0]       cnt_cur, cnt_new;
   logic              clear_all;

   assign adv_out = !out_valid_ff || out_ready;
   assign move    = s1_valid_ff && adv_out;
   // hold the next frame's first slot until the frame-end clear has landed
   assign load    = q_valid && (!s1_valid_ff || adv_out) &&
                    !(s1_valid_ff && (s1_ff.slot == LAST_SLOT));
   assign q_pop   = load && (sel_ff == LAST_SLOT);

   // stage 1: decode the selected slot
   always_comb begin
      slot_bytes = q_data[sel_ff];
      slot_dist  = {slot_bytes[63:56], slot_bytes[55:48]};
      abs_speed  = {slot_bytes[46:40], slot_bytes[39:32]};
      prev_dist  = prev_ff[sel_ff];
      dist_delta = (slot_dist >= prev_dist) ? (slot_dist - prev_dist) :
                                              (prev_dist - slot_dist);

      s1_in.slot     = sel_ff;
      s1_in.pos_x    = decode_sm(slot_bytes[7:0],   slot_bytes[15:8]);
      s1_in.pos_y    = decode_sm(slot_bytes[23:16], slot_bytes[31:24]);
      s1_in.speed    = decode_sm(slot_bytes[39:32], slot_bytes[47:40]);
      s1_in.distance = slot_dist;
      s1_in.valid    = (slot_dist != '0) && (slot_dist < cfg.max_distance_mm);
      s1_in.still_ok = (abs_speed < cfg.still_speed_cms) &&
                       (dist_delta < cfg.still_distance_tolerance_mm);
      s1_in.approaching = s1_in.valid && (s1_in.speed <= cfg.receding_limit_cms);

      sel_in      = sel_ff;
      s1_valid_in = s1_valid_ff;
      if (load) begin
         sel_in      = (sel_ff == LAST_SLOT) ? '0 : sel_ff + 1'b1;
         s1_valid_in = 1'b1;
      end else if (move) begin
         s1_valid_in = 1'b0;
      end
   end

   // stage 2: counter update and result
   always_comb begin
      cnt_cur = cnt_ff[s1_ff.slot];
      if (!s1_ff.still_ok) begin
         cnt_new = '0;
      end else if (cnt_cur == COUNT_MAX) begin
         cnt_new = cnt_cur;
      end else begin
         cnt_new = cnt_cur + 1'b1;
      end

      out_in.slot_index    = s1_ff.slot;
      out_in.target_valid  = s1_ff.valid;
      out_in.pos_x_mm      = s1_ff.pos_x;
      out_in.pos_y_mm      = s1_ff.pos_y;
      out_in.speed_cms     = s1_ff.speed;
      out_in.distance_mm   = s1_ff.distance;
      out_in.still_frames  = s1_ff.valid ? cnt_new : '0;
      out_in.is_static     = s1_ff.valid && (cnt_new >= cfg.static_min_frames);
      out_in.approaching   = s1_ff.approaching;
      out_in.last_of_frame = (s1_ff.slot == LAST_SLOT);

      any_valid_in = (s1_ff.slot == '0) ? s1_ff.valid : (any_valid_ff || s1_ff.valid);
      clear_all    = (s1_ff.slot == LAST_SLOT) && !any_valid_in;

      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff <= s1_in;
      end
      if (move) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         any_valid_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            prev_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         sel_ff       <= sel_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (move) begin
            any_valid_ff <= any_valid_in;
            if (clear_all) begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  prev_ff[i] <= '0;
                  cnt_ff[i]  <= '0;
               end
            end else if (s1_ff.valid) begin
               prev_ff[s1_ff.slot] <= s1_ff.distance;
               cnt_ff[s1_ff.slot]  <= cnt_new;
            end
         end
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule
`default_nettype wire

// ===== hdl/radar_target_frame_decoder.sv =====
// Top level: configuration registers, front end, frame queue and slot decoder.
// Takes one byte per cycle, stalling only while the queue (two frames) is full;
// a byte that closes a frame yields three results through the queue, decode
// and result registers, one per cycle while rsp_tready is high.
// Synchronous active-high reset clears the window, counters and queue and
// loads the register defaults.
`default_nettype none
module radar_target_frame_decoder (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,  // [7:0] rx_byte
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [1:0] slot_index, [2] target_valid, [18:3] pos_x_mm, [34:19] pos_y_mm,
   // [50:35] speed_cms, [66:51] distance_mm, [82:67] still_frames,
   // [83] is_static, [84] approaching, [87:85] zero
   output logic [rtfd_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast,  // last_of_frame
   input  wire logic                              csr_we,
   input  wire logic [rtfd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [rtfd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rtfd_pkg::*;

   cfg_type    cfg_ff;
   logic       q_full, q_push, q_pop, q_valid;
   frame_type  q_push_data, q_head;
   result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_distance_mm             <= 16'd8000;
         cfg_ff.still_speed_cms             <= 15'd83;
         cfg_ff.still_distance_tolerance_mm <= 16'd100;
         cfg_ff.static_min_frames           <= 16'd80;
         cfg_ff.receding_limit_cms          <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MAX_DISTANCE:   cfg_ff.max_distance_mm             <= csr_wdata;
            CSR_STILL_SPEED:    cfg_ff.still_speed_cms             <= csr_wdata[14:0];
            CSR_DIST_TOLERANCE: cfg_ff.still_distance_tolerance_mm <= csr_wdata;
            CSR_STATIC_MIN:     cfg_ff.static_min_frames           <= csr_wdata;
            CSR_RECEDING_LIMIT: cfg_ff.receding_limit_cms          <= signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   rtfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   rtfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   rtfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_data     (q_head),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {3'b000, result.approaching, result.is_static, result.still_frames,
                       result.distance_mm, result.speed_cms, result.pos_y_mm,
                       result.pos_x_mm, result.target_valid, result.slot_index};
   assign rsp_tlast = result.last_of_frame;

endmodule
`default_nettype wire
